>>> design/vmtfdq_pkg.sv
package vmtfdq_pkg;

    localparam int NUM_VARS = 1024;
    localparam int VAR_W = 10;
    localparam int STAMP_W = 32;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_MTF = 2'd2;

    typedef struct packed {
        logic             v;
        logic [VAR_W-1:0] idx;
    } link_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_FETCH,
        OP_DECIDE,
        OP_UNLINK_A,
        OP_UNLINK_B,
        OP_APPEND_A,
        OP_APPEND_B,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_WALK_NEXT,
        OP_FINISH_A,
        OP_FINISH_B,
        OP_FINISH_C,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_DECIDE,
        ST_UNLINK_A,
        ST_UNLINK_B,
        ST_APPEND_A,
        ST_APPEND_B,
        ST_WALK_INIT,
        ST_WALK_STEP,
        ST_WALK_NEXT,
        ST_FINISH_A,
        ST_FINISH_B,
        ST_FINISH_C,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic accept;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] req;
        logic       is_tail;
        logic       renum;
        logic       walk_done;
        logic       clear_done;
    } status_t;

endpackage

>>> design/vmtfdq_dp.sv
module vmtfdq_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vmtfdq_pkg::cmd_t                cmd,
    output vmtfdq_pkg::status_t             stat,
    input  logic [1:0]                      req_type,
    input  logic [vmtfdq_pkg::VAR_W-1:0]    var_index,
    input  logic                            var_assigned,
    output logic                            status,
    output logic [vmtfdq_pkg::STAMP_W-1:0]  item_stamp,
    output logic                            head_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    head_index,
    output logic                            tail_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    tail_index,
    output logic                            search_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    search_index,
    output logic [vmtfdq_pkg::STAMP_W-1:0]  search_mark
);
    import vmtfdq_pkg::*;

    link_t               prev_mem [NUM_VARS];
    link_t               next_mem [NUM_VARS];
    logic [STAMP_W-1:0]  stamp_mem [NUM_VARS];

    link_t               prev_rd_reg;
    link_t               next_rd_reg;
    logic [STAMP_W-1:0]  stamp_rd_reg;

    logic [1:0]          req_reg;
    logic [VAR_W-1:0]    idx_reg;
    logic                asg_reg;
    link_t               p_reg;
    link_t               n_reg;
    link_t               head_reg;
    link_t               tail_reg;
    link_t               last_reg;
    link_t               search_reg;
    link_t               walk_reg;
    logic [VAR_W:0]      steps_reg;
    logic [STAMP_W-1:0]  counter_reg;
    logic [STAMP_W-1:0]  sstamp_reg;
    logic [STAMP_W-1:0]  item_reg;
    logic                bad_reg;
    logic                reload_reg;
    logic                renum_reg;
    logic [VAR_W-1:0]    clr_reg;

    logic                pw_en;
    logic [VAR_W-1:0]    pw_addr;
    link_t               pw_data;
    logic                nw_en;
    logic [VAR_W-1:0]    nw_addr;
    link_t               nw_data;
    logic                sw_en;
    logic [VAR_W-1:0]    sw_addr;
    logic [STAMP_W-1:0]  sw_data;
    logic [VAR_W-1:0]    next_ra;
    logic [VAR_W-1:0]    stamp_ra;

    logic                in_list;
    logic                bad_c;
    logic                hit;
    logic                walk_done;
    logic [STAMP_W-1:0]  counter_inc;
    link_t               self_link;

    assign self_link   = '{v: 1'b1, idx: idx_reg};
    assign counter_inc = counter_reg + 1'b1;
    assign in_list     = p_reg.v || n_reg.v || (head_reg.v && head_reg.idx == idx_reg);
    assign hit         = search_reg.v && search_reg.idx == idx_reg;
    assign walk_done   = !walk_reg.v || steps_reg == (VAR_W+1)'(NUM_VARS);

    always_comb
    begin
        bad_c = 1'b0;
        if ({1'b0, idx_reg} >= (VAR_W+1)'(NUM_VARS))
        begin
            bad_c = 1'b1;
        end
        else
        begin
            case (req_reg)
                REQ_ENQ: bad_c = in_list;
                REQ_DEQ: bad_c = !in_list;
                REQ_MTF: bad_c = !in_list;
                default: bad_c = 1'b1;
            endcase
        end
    end

    assign stat.bad        = bad_c;
    assign stat.req        = req_reg;
    assign stat.is_tail    = tail_reg.v && tail_reg.idx == idx_reg;
    assign stat.renum      = renum_reg;
    assign stat.walk_done  = walk_done;
    assign stat.clear_done = clr_reg == VAR_W'(NUM_VARS - 1);

    assign next_ra  = (cmd.op == OP_WALK_STEP) ? walk_reg.idx : var_index;
    assign stamp_ra = (cmd.op == OP_FINISH_A) ? idx_reg : search_reg.idx;

    always_comb
    begin
        pw_en   = 1'b0;
        pw_addr = idx_reg;
        pw_data = '0;
        nw_en   = 1'b0;
        nw_addr = idx_reg;
        nw_data = '0;
        sw_en   = 1'b0;
        sw_addr = idx_reg;
        sw_data = counter_inc;
        case (cmd.op)
            OP_CLEAR:
            begin
                pw_en   = 1'b1;
                pw_addr = clr_reg;
                nw_en   = 1'b1;
                nw_addr = clr_reg;
            end
            OP_UNLINK_A:
            begin
                pw_en = 1'b1;
                nw_en = 1'b1;
            end
            OP_UNLINK_B:
            begin
                nw_en   = p_reg.v;
                nw_addr = p_reg.idx;
                nw_data = n_reg;
                pw_en   = n_reg.v;
                pw_addr = n_reg.idx;
                pw_data = p_reg;
            end
            OP_APPEND_A:
            begin
                pw_en   = 1'b1;
                pw_data = tail_reg;
                nw_en   = 1'b1;
                sw_en   = counter_reg != STAMP_MAX;
            end
            OP_APPEND_B:
            begin
                nw_en   = last_reg.v;
                nw_addr = last_reg.idx;
                nw_data = self_link;
            end
            OP_WALK_STEP:
            begin
                sw_en   = !walk_done;
                sw_addr = walk_reg.idx;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            prev_mem[pw_addr] <= pw_data;
        end
        prev_rd_reg <= prev_mem[var_index];
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            stamp_mem[sw_addr] <= sw_data;
        end
        stamp_rd_reg <= stamp_mem[stamp_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            search_reg   <= '0;
            counter_reg  <= '0;
            sstamp_reg   <= '0;
            clr_reg      <= '0;
            renum_reg    <= 1'b0;
            reload_reg   <= 1'b0;
            bad_reg      <= 1'b0;
            walk_reg     <= '0;
            steps_reg    <= '0;
            last_reg     <= '0;
            req_reg      <= '0;
            idx_reg      <= '0;
            asg_reg      <= 1'b0;
            p_reg        <= '0;
            n_reg        <= '0;
            item_reg     <= '0;
            status       <= 1'b0;
            item_stamp   <= '0;
            head_valid   <= 1'b0;
            head_index   <= '0;
            tail_valid   <= 1'b0;
            tail_index   <= '0;
            search_valid <= 1'b0;
            search_index <= '0;
            search_mark  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                req_reg <= req_type;
                idx_reg <= var_index;
                asg_reg <= var_assigned;
            end
            case (cmd.op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                OP_FETCH:
                begin
                    p_reg      <= prev_rd_reg;
                    n_reg      <= next_rd_reg;
                    reload_reg <= 1'b0;
                end
                OP_DECIDE:
                begin
                    bad_reg <= bad_c;
                    if (!bad_c && req_reg == REQ_DEQ && hit)
                    begin
                        if (n_reg.v)
                        begin
                            search_reg <= n_reg;
                            reload_reg <= 1'b1;
                        end
                        else if (p_reg.v)
                        begin
                            search_reg <= p_reg;
                            reload_reg <= 1'b1;
                        end
                        else
                        begin
                            search_reg <= '0;
                            sstamp_reg <= '0;
                        end
                    end
                    if (!bad_c && req_reg == REQ_MTF && !stat.is_tail && asg_reg && hit)
                    begin
                        if (p_reg.v)
                        begin
                            search_reg <= p_reg;
                            reload_reg <= 1'b1;
                        end
                        else if (n_reg.v)
                        begin
                            search_reg <= n_reg;
                            reload_reg <= 1'b1;
                        end
                    end
                end
                OP_UNLINK_A:
                begin
                    if (!p_reg.v)
                    begin
                        head_reg <= n_reg;
                    end
                    if (!n_reg.v)
                    begin
                        tail_reg <= p_reg;
                    end
                end
                OP_APPEND_A:
                begin
                    last_reg  <= tail_reg;
                    tail_reg  <= self_link;
                    renum_reg <= counter_reg == STAMP_MAX;
                    if (!tail_reg.v)
                    begin
                        head_reg <= self_link;
                    end
                    if (counter_reg != STAMP_MAX)
                    begin
                        counter_reg <= counter_inc;
                    end
                    if (!asg_reg)
                    begin
                        search_reg <= self_link;
                        reload_reg <= 1'b1;
                    end
                end
                OP_WALK_INIT:
                begin
                    counter_reg <= '0;
                    walk_reg    <= head_reg;
                    steps_reg   <= '0;
                    if (search_reg.v)
                    begin
                        reload_reg <= 1'b1;
                    end
                end
                OP_WALK_STEP:
                begin
                    if (!walk_done)
                    begin
                        counter_reg <= counter_inc;
                        steps_reg   <= steps_reg + 1'b1;
                    end
                end
                OP_WALK_NEXT:
                begin
                    walk_reg <= next_rd_reg;
                end
                OP_FINISH_B:
                begin
                    item_reg <= bad_reg ? '0 : stamp_rd_reg;
                end
                OP_FINISH_C:
                begin
                    if (reload_reg && search_reg.v)
                    begin
                        sstamp_reg <= stamp_rd_reg;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.load_out)
            begin
                status       <= bad_reg;
                item_stamp   <= item_reg;
                head_valid   <= head_reg.v;
                head_index   <= head_reg.v ? head_reg.idx : '0;
                tail_valid   <= tail_reg.v;
                tail_index   <= tail_reg.v ? tail_reg.idx : '0;
                search_valid <= search_reg.v;
                search_index <= search_reg.v ? search_reg.idx : '0;
                search_mark  <= sstamp_reg;
            end
        end
    end

`ifndef SYNTH
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg.v == tail_reg.v)
        else $error("head and tail validity differ");
    a_search_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        search_reg.v |-> head_reg.v)
        else $error("search pointer set on an empty queue");
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND_A && counter_reg != STAMP_MAX)
        |=> counter_reg == STAMP_W'($past(counter_reg) + 1'b1))
        else $error("stamp counter did not advance on append");
`endif

endmodule

>>> design/vmtfdq_ctrl.sv
module vmtfdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  vmtfdq_pkg::status_t stat,
    output vmtfdq_pkg::cmd_t    cmd
);
    import vmtfdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign out_valid = out_valid_reg;
    assign in_stall  = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_IDLE;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.op     = OP_FETCH;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op = OP_DECIDE;
                if (stat.bad)
                begin
                    state_next = ST_FINISH_A;
                end
                else
                begin
                    case (stat.req)
                        REQ_ENQ: state_next = ST_APPEND_A;
                        REQ_DEQ: state_next = ST_UNLINK_A;
                        REQ_MTF: state_next = stat.is_tail ? ST_FINISH_A : ST_UNLINK_A;
                        default: state_next = ST_FINISH_A;
                    endcase
                end
            end
            ST_UNLINK_A:
            begin
                cmd.op     = OP_UNLINK_A;
                state_next = ST_UNLINK_B;
            end
            ST_UNLINK_B:
            begin
                cmd.op     = OP_UNLINK_B;
                state_next = (stat.req == REQ_DEQ) ? ST_FINISH_A : ST_APPEND_A;
            end
            ST_APPEND_A:
            begin
                cmd.op     = OP_APPEND_A;
                state_next = ST_APPEND_B;
            end
            ST_APPEND_B:
            begin
                cmd.op     = OP_APPEND_B;
                state_next = stat.renum ? ST_WALK_INIT : ST_FINISH_A;
            end
            ST_WALK_INIT:
            begin
                cmd.op     = OP_WALK_INIT;
                state_next = ST_WALK_STEP;
            end
            ST_WALK_STEP:
            begin
                cmd.op     = OP_WALK_STEP;
                state_next = stat.walk_done ? ST_FINISH_A : ST_WALK_NEXT;
            end
            ST_WALK_NEXT:
            begin
                cmd.op     = OP_WALK_NEXT;
                state_next = ST_WALK_STEP;
            end
            ST_FINISH_A:
            begin
                cmd.op     = OP_FINISH_A;
                state_next = ST_FINISH_B;
            end
            ST_FINISH_B:
            begin
                cmd.op     = OP_FINISH_B;
                state_next = ST_FINISH_C;
            end
            ST_FINISH_C:
            begin
                cmd.op     = OP_FINISH_C;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

>>> design/vmtf_decision_queue.sv
// channel | handshake                   | payload
// in      | in_valid / in_stall          | req_type, var_index, var_assigned
// out     | out_valid / out_stall        | status, item_stamp, head/tail/search fields
//
// Enqueue appends at the tail, dequeue unlinks, move-to-front unlinks and then
// appends; ignored requests and move-to-front of the tail change no links.
// Renumbering on stamp overflow walks the list from the head, restamping each entry.
// After reset the link memories are cleared, all 1024 entries, with in_stall high.
// in_stall drops as the result is registered; a result held by out_stall
// blocks the next result, not the next acceptance.
module vmtf_decision_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      req_type,
    input  logic [vmtfdq_pkg::VAR_W-1:0]    var_index,
    input  logic                            var_assigned,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic [vmtfdq_pkg::STAMP_W-1:0]  item_stamp,
    output logic                            head_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    head_index,
    output logic                            tail_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    tail_index,
    output logic                            search_valid,
    output logic [vmtfdq_pkg::VAR_W-1:0]    search_index,
    output logic [vmtfdq_pkg::STAMP_W-1:0]  search_mark
);
    import vmtfdq_pkg::*;

    cmd_t    cmd;
    status_t stat;

    vmtfdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    vmtfdq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .var_index    (var_index),
        .var_assigned (var_assigned),
        .status       (status),
        .item_stamp   (item_stamp),
        .head_valid   (head_valid),
        .head_index   (head_index),
        .tail_valid   (tail_valid),
        .tail_index   (tail_index),
        .search_valid (search_valid),
        .search_index (search_index),
        .search_mark  (search_mark)
    );

endmodule
